// ===== design/assert_macros.svh =====
// Assertion helpers for the design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the same clock edge.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked on the following clock edge.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/mps_pkg.sv =====
package mps_pkg;
    localparam int ModulusBits = 16;
    localparam int LenBits     = $clog2(ModulusBits + 1);
    localparam int IdxBits     = $clog2(ModulusBits);

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EVEN  = 2'd1,
        ST_SMALL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEN,
        S_INV,
        S_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic len_step;
        logic inv_start;
        logic inv_step;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic tmp_zero;
        logic inv_done;
        logic no_inverse;
    } sts_t;
endpackage

// ===== design/mps_ctrl.sv =====
module mps_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  mps_pkg::sts_t sts,
    output mps_pkg::cmd_t cmd
);
    import mps_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   slot_free;

    assign slot_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid) state_next = S_LEN;
            S_LEN: begin
                if (sts.tmp_zero) state_next = sts.no_inverse ? S_FIN : S_INV;
            end
            S_INV: if (sts.inv_done) state_next = S_FIN;
            S_FIN: if (slot_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE: cmd.load = s_valid;
            S_LEN: begin
                cmd.len_step  = !sts.tmp_zero;
                cmd.inv_start = sts.tmp_zero;
            end
            S_INV: cmd.inv_step = !sts.inv_done;
            S_FIN: cmd.publish = slot_free;
            default: cmd = '0;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (cmd.publish) m_valid_next = 1'b1;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
endmodule

// ===== design/mps_dpath.sv =====
module mps_dpath (
    input  logic                                aclk,
    input  logic [mps_pkg::ModulusBits-1:0]     s_modulus,
    input  mps_pkg::cmd_t                       cmd,
    output mps_pkg::sts_t                       sts,
    output logic [4:0]                          m_bit_length,
    output logic [16:0]                         m_radix,
    output logic [15:0]                         m_n_prime,
    output logic [1:0]                          m_status
);
    import mps_pkg::*;

    logic [ModulusBits-1:0] n_reg, tmp_reg, y_reg;
    logic [ModulusBits:0]   s_reg, s_sum;
    logic [LenBits-1:0]     k_reg, i_reg;
    status_t                status;
    logic [4:0]             bl_reg;
    logic [16:0]            radix_reg;
    logic [15:0]            np_reg;
    logic [1:0]             st_reg;

    always_comb begin
        if (n_reg < ModulusBits'(2)) status = ST_SMALL;
        else if (!n_reg[0]) status = ST_EVEN;
        else status = ST_OK;
    end

    assign s_sum = s_reg + {1'b0, n_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            n_reg   <= s_modulus;
            tmp_reg <= s_modulus;
            k_reg   <= '0;
        end
        if (cmd.len_step) begin
            tmp_reg <= tmp_reg >> 1;
            k_reg   <= k_reg + LenBits'(1);
        end
        if (cmd.inv_start) begin
            s_reg <= (ModulusBits + 1)'(1);
            y_reg <= '0;
            i_reg <= '0;
        end
        if (cmd.inv_step) begin
            if (s_reg[0]) begin
                s_reg            <= s_sum >> 1;
                y_reg[i_reg[IdxBits-1:0]] <= 1'b1;
            end else begin
                s_reg <= s_reg >> 1;
            end
            i_reg <= i_reg + LenBits'(1);
        end
        if (cmd.publish) begin
            bl_reg    <= 5'(k_reg);
            radix_reg <= 17'(1) << k_reg;
            np_reg    <= (status == ST_OK) ? 16'(y_reg) : 16'd0;
            st_reg    <= status;
        end
    end

    assign sts.tmp_zero   = (tmp_reg == '0);
    assign sts.inv_done   = (i_reg == k_reg);
    assign sts.no_inverse = (status != ST_OK);

    assign m_bit_length = bl_reg;
    assign m_radix      = radix_reg;
    assign m_n_prime    = np_reg;
    assign m_status     = st_reg;
endmodule

// ===== design/montgomery_parameter_setup.sv =====
// Channel | Direction | Ports
// input   | in        | s_valid, s_ready, s_modulus
// result  | out       | m_valid, m_ready, m_bit_length, m_radix, m_n_prime, m_status
//
// One word is taken at a time; the result for an odd modulus is loaded after the
// bit-length count in S_LEN and the bit-serial inverse loop in S_INV.
// An even modulus, zero or one skips the inverse loop and goes from S_LEN straight to S_FIN.
// The next word can be taken in the cycle after the result is loaded.
// Reset is synchronous and active low and clears the controller only.
// A finished result waits in the output register while the next word is taken.
module montgomery_parameter_setup (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_modulus,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_bit_length,
    output logic [16:0] m_radix,
    output logic [15:0] m_n_prime,
    output logic [1:0]  m_status
);
    import mps_pkg::*;
    `include "assert_macros.svh"

    cmd_t cmd;
    sts_t sts;

    mps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mps_dpath u_dpath (
        .aclk         (aclk),
        .s_modulus    (s_modulus),
        .cmd          (cmd),
        .sts          (sts),
        .m_bit_length (m_bit_length),
        .m_radix      (m_radix),
        .m_n_prime    (m_n_prime),
        .m_status     (m_status)
    );

    `ASSERT_IMPL(a_radix, aclk, aresetn, m_valid, m_radix == (17'(1) << m_bit_length))
    `ASSERT_IMPL(a_np_zero, aclk, aresetn, m_valid && (m_status != ST_OK), m_n_prime == 16'd0)
    `ASSERT_IMPL(a_np_odd, aclk, aresetn, m_valid && (m_status == ST_OK), m_n_prime[0])
    `ASSERT_NEXT(a_load_busy, aclk, aresetn, s_valid && s_ready, !s_ready)
endmodule
